// ===== sv/hsps_pkg.sv =====
package hsps_pkg;

    // Field and register widths.
    localparam int VLEN_W   = 14;
    localparam int IRL_W    = 17;
    localparam int VALUE_W  = 24;
    localparam int DELTA_W  = 25;
    localparam int FEAT_W   = 32;
    localparam int COARSE_W = 20;

    // Result layout: feature and coarse fields that exist on the output item.
    localparam int FEATURE_FIELDS = 4;
    localparam int COARSE_FIELDS  = 2;

    // Stream and register port widths.
    localparam int S_DATA_W     = 4 * VALUE_W;
    localparam int M_DATA_BITS  = DELTA_W + FEATURE_FIELDS * FEAT_W + COARSE_FIELDS * COARSE_W;
    localparam int M_DATA_W     = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_ADDR_LSB = 2;

    // Default sizes of the design.
    localparam int DEF_MAX_LENGTH    = 8192;
    localparam int DEF_FEATURE_COUNT = 4;
    localparam int DEF_COARSE_COUNT  = 2;

    // Register reset values.
    localparam logic [VLEN_W-1:0] VLEN_RESET = 14'd4096;
    localparam logic [IRL_W-1:0]  IRL_RESET  = 17'd1024;

    // Fixed-point scaling: Q16.16 product shift, and sixteenths from Q16.16.
    localparam int FEAT_FRAC_SHIFT = 16;
    localparam int COARSE_SHIFT    = 12;

    // Sign hash constants.
    localparam logic [31:0] HASH_MUL_FEATURE     = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_COORD       = 32'd2246822519;
    localparam int          HASH_FEATURE_OFFSET  = 3;
    localparam int          HASH_COORD_OFFSET    = 29;
    localparam int          HASH_SHIFT           = 13;
    localparam int          HASH_W               = HASH_SHIFT + 1;

    // Saturation limits of a feature.
    localparam logic signed [63:0] FEAT_MAX_C = 64'sd2147483647;
    localparam logic signed [63:0] FEAT_MIN_C = -64'sd2147483648;

    typedef enum logic {
        REG_VECTOR_LENGTH = 1'b0,
        REG_INVERSE_ROOT  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [VLEN_W-1:0] vector_length;
        logic [IRL_W-1:0]  inverse_root_length;
    } regs_t;

    // Accumulator width: one difference grown by the longest vector.
    function automatic int sum_width(input int max_length);
        return DELTA_W + $clog2(max_length);
    endfunction

    function automatic int lane_count(input int feature_count);
        return (feature_count < FEATURE_FIELDS) ? feature_count : FEATURE_FIELDS;
    endfunction

    function automatic int coarse_lanes(input int coarse_count, input int feature_count);
        int n;
        n = (coarse_count < COARSE_FIELDS) ? coarse_count : COARSE_FIELDS;
        return (n < lane_count(feature_count)) ? n : lane_count(feature_count);
    endfunction

    // Feature half of the hash: bits 0 and 13 of (f + 3) * multiplier.
    function automatic logic feature_hash_bit(input int feature);
        logic [63:0] p;
        p = 64'(feature + HASH_FEATURE_OFFSET) * 64'(HASH_MUL_FEATURE);
        return p[0] ^ p[HASH_SHIFT];
    endfunction

    // Coordinate half of the hash. Only the low 14 bits of the product matter.
    function automatic logic coord_hash_bit(input logic [HASH_W-1:0] coord);
        logic [HASH_W-1:0] t;
        logic [HASH_W-1:0] m;
        t = coord + HASH_W'(HASH_COORD_OFFSET);
        m = t * HASH_MUL_COORD[HASH_W-1:0];
        return m[0] ^ m[HASH_SHIFT];
    endfunction

endpackage

// ===== sv/hashed_sign_projection_sketch.sv =====
// Channel    Direction  Payload
// s_axis     in         tdata: clean_value, intervened_value, clean_margin,
//                       intervened_margin (24 bits each)
// m_axis     out        tdata: target_delta, feature_zero..feature_three,
//                       coarse_zero, coarse_one, zero fill
// apb        in/out     vector_length at 0x0, inverse_root_length at 0x4
//
// One coordinate item is accepted every cycle while no final coordinate is
// waiting for room; the per-feature add/subtract in the accumulator lanes is the
// only work on the item path. After its final coordinate is accepted, a result
// passes the input register, snapshot, multiply, round/saturate and pack to m_axis.
// Reset clears the input register, counter, sums and result stages at once;
// registers return to 4096 and 1024. No clearing pass is needed.
// Non-final coordinates keep flowing while results wait; a final coordinate
// waits only when all four result stages are full.
module hashed_sign_projection_sketch #(
    parameter int MAX_LENGTH    = hsps_pkg::DEF_MAX_LENGTH,
    parameter int FEATURE_COUNT = hsps_pkg::DEF_FEATURE_COUNT,
    parameter int COARSE_COUNT  = hsps_pkg::DEF_COARSE_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // clean_value[23:0], intervened_value[47:24], clean_margin[71:48],
    // intervened_margin[95:72]
    input  logic [hsps_pkg::S_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // target_delta[24:0], feature_zero[56:25], feature_one[88:57],
    // feature_two[120:89], feature_three[152:121], coarse_zero[172:153],
    // coarse_one[192:173], zero[199:193]
    output logic [hsps_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hsps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hsps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hsps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import hsps_pkg::*;

    localparam int SUM_W = sum_width(MAX_LENGTH);
    localparam int LANES = lane_count(FEATURE_COUNT);

    regs_t regs;

    // Input register.
    logic                      a_valid_reg;
    logic signed [VALUE_W-1:0] a_clean_reg;
    logic signed [VALUE_W-1:0] a_interv_reg;
    logic signed [VALUE_W-1:0] a_cmargin_reg;
    logic signed [VALUE_W-1:0] a_imargin_reg;

    logic                      a_go;
    logic                      acc_last;
    logic                      fin_ready;
    logic                      fin_in_valid;
    logic                      s_accept;
    logic signed [DELTA_W-1:0] diff;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   totals [LANES];

    hsps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    // A final coordinate needs room in the result stages; others never wait.
    assign a_go          = a_valid_reg && (!acc_last || fin_ready);
    assign s_axis_tready = !a_valid_reg || a_go;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign fin_in_valid  = a_go && acc_last;

    assign diff  = {a_interv_reg[VALUE_W-1], a_interv_reg}
                 - {a_clean_reg[VALUE_W-1], a_clean_reg};
    assign delta = {a_imargin_reg[VALUE_W-1], a_imargin_reg}
                 - {a_cmargin_reg[VALUE_W-1], a_cmargin_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (s_accept)
            a_valid_reg <= 1'b1;
        else if (a_go)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_clean_reg   <= s_axis_tdata[VALUE_W-1:0];
            a_interv_reg  <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
            a_cmargin_reg <= s_axis_tdata[3*VALUE_W-1:2*VALUE_W];
            a_imargin_reg <= s_axis_tdata[4*VALUE_W-1:3*VALUE_W];
        end
    end

    hsps_accum #(
        .MAX_LENGTH    (MAX_LENGTH),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (a_go),
        .diff          (diff),
        .vector_length (regs.vector_length),
        .last          (acc_last),
        .totals        (totals)
    );

    hsps_finish #(
        .MAX_LENGTH    (MAX_LENGTH),
        .FEATURE_COUNT (FEATURE_COUNT),
        .COARSE_COUNT  (COARSE_COUNT)
    ) u_finish (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (fin_in_valid),
        .in_ready            (fin_ready),
        .in_delta            (delta),
        .in_sums             (totals),
        .inverse_root_length (regs.inverse_root_length),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata)
    );

    a_final_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        fin_in_valid |-> fin_ready)
        else $error("final coordinate released into full result stages");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> a_valid_reg && acc_last)
        else $error("input stalled without a blocked final coordinate");

endmodule

// ===== sv/hsps_cfg.sv =====
module hsps_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hsps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hsps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hsps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output hsps_pkg::regs_t                    regs
);
    import hsps_pkg::*;

    logic [VLEN_W-1:0] vector_length_reg;
    logic [IRL_W-1:0]  inverse_root_reg;
    reg_index_t        sel;
    logic              wr_en;

    // Each register sits on a word boundary; low address bits are ignored.
    assign sel    = reg_index_t'(paddr[REG_ADDR_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= VLEN_RESET;
            inverse_root_reg  <= IRL_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_VECTOR_LENGTH: vector_length_reg <= pwdata[VLEN_W-1:0];
                REG_INVERSE_ROOT:  inverse_root_reg  <= pwdata[IRL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (sel)
            REG_VECTOR_LENGTH: prdata = APB_DATA_W'(vector_length_reg);
            REG_INVERSE_ROOT:  prdata = APB_DATA_W'(inverse_root_reg);
            default:           prdata = '0;
        endcase
    end

    assign regs.vector_length       = vector_length_reg;
    assign regs.inverse_root_length = inverse_root_reg;

endmodule

// ===== sv/hsps_accum.sv =====
module hsps_accum #(
    parameter int MAX_LENGTH    = hsps_pkg::DEF_MAX_LENGTH,
    parameter int FEATURE_COUNT = hsps_pkg::DEF_FEATURE_COUNT
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  step,
    input  logic signed [hsps_pkg::DELTA_W-1:0]                   diff,
    input  logic [hsps_pkg::VLEN_W-1:0]                           vector_length,
    output logic                                                  last,
    output logic signed [hsps_pkg::sum_width(MAX_LENGTH)-1:0]
                        totals [hsps_pkg::lane_count(FEATURE_COUNT)]
);
    import hsps_pkg::*;

    localparam int SUM_W = sum_width(MAX_LENGTH);
    localparam int LANES = lane_count(FEATURE_COUNT);
    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int CMP_W = (IDX_W + 1 > VLEN_W) ? IDX_W + 1 : VLEN_W;

    logic [IDX_W-1:0]       idx_reg;
    logic signed [SUM_W-1:0] sums_reg [LANES];
    logic [31:0]            coord_wide;
    logic                   coord_bit;
    logic [CMP_W-1:0]       len_ext;
    logic [CMP_W-1:0]       eff_len;
    logic signed [SUM_W-1:0] diff_ext;

    // Effective length: zero acts as one, anything beyond the maximum is clipped.
    always_comb
    begin
        len_ext = CMP_W'(vector_length);
        if (len_ext == '0)
            eff_len = CMP_W'(1);
        else if (len_ext > CMP_W'(MAX_LENGTH))
            eff_len = CMP_W'(MAX_LENGTH);
        else
            eff_len = len_ext;
    end

    assign last = (CMP_W'(idx_reg) + CMP_W'(1)) >= eff_len;

    // The coordinate part of the sign hash is shared by all features.
    assign coord_wide = 32'(idx_reg);
    assign coord_bit  = coord_hash_bit(coord_wide[HASH_W-1:0]);
    assign diff_ext   = SUM_W'(diff);

    // Add or subtract the difference in every feature lane.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (feature_hash_bit(i) ^ coord_bit)
                totals[i] = sums_reg[i] + diff_ext;
            else
                totals[i] = sums_reg[i] - diff_ext;
        end
    end

    // Running sums and coordinate counter; both clear after the last coordinate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int i = 0; i < LANES; i++)
                sums_reg[i] <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                idx_reg <= '0;
                for (int i = 0; i < LANES; i++)
                    sums_reg[i] <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                for (int i = 0; i < LANES; i++)
                    sums_reg[i] <= totals[i];
            end
        end
    end

    a_idx_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> idx_reg == '0)
        else $error("coordinate index did not clear after the last coordinate");

    a_idx_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last |=> idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("coordinate index did not advance by one");

endmodule

// ===== sv/hsps_finish.sv =====
module hsps_finish #(
    parameter int MAX_LENGTH    = hsps_pkg::DEF_MAX_LENGTH,
    parameter int FEATURE_COUNT = hsps_pkg::DEF_FEATURE_COUNT,
    parameter int COARSE_COUNT  = hsps_pkg::DEF_COARSE_COUNT
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic signed [hsps_pkg::DELTA_W-1:0]                   in_delta,
    input  logic signed [hsps_pkg::sum_width(MAX_LENGTH)-1:0]
                        in_sums [hsps_pkg::lane_count(FEATURE_COUNT)],
    input  logic [hsps_pkg::IRL_W-1:0]                            inverse_root_length,
    output logic                                                  m_axis_tvalid,
    input  logic                                                  m_axis_tready,
    output logic [hsps_pkg::M_DATA_W-1:0]                         m_axis_tdata
);
    import hsps_pkg::*;

    localparam int SUM_W  = sum_width(MAX_LENGTH);
    localparam int LANES  = lane_count(FEATURE_COUNT);
    localparam int CLANES = coarse_lanes(COARSE_COUNT, FEATURE_COUNT);
    localparam int PROD_W = SUM_W + IRL_W + 1;
    localparam int RND_W  = PROD_W - FEAT_FRAC_SHIFT;
    localparam int SAT_W  = (RND_W > FEAT_W + 1) ? RND_W : FEAT_W + 1;
    localparam int CSUM_W = FEAT_W + 1;
    localparam int CRND_W = CSUM_W - COARSE_SHIFT;
    localparam int COARSE_LSB = DELTA_W + FEATURE_FIELDS * FEAT_W;

    localparam logic [PROD_W-1:0] FHALF = PROD_W'(1) << (FEAT_FRAC_SHIFT - 1);
    localparam logic [CSUM_W-1:0] CHALF = CSUM_W'(1) << (COARSE_SHIFT - 1);
    localparam logic signed [SAT_W-1:0]  SAT_MAX = SAT_W'(FEAT_MAX_C);
    localparam logic signed [SAT_W-1:0]  SAT_MIN = SAT_W'(FEAT_MIN_C);
    localparam logic signed [CRND_W-1:0] CMAX = CRND_W'(2 ** (COARSE_W - 1) - 1);
    localparam logic signed [CRND_W-1:0] CMIN = CRND_W'(-(2 ** (COARSE_W - 1)));

    // Snapshot stage: final sums and margin difference of a vector.
    logic                     b_valid_reg;
    logic signed [DELTA_W-1:0] b_delta_reg;
    logic signed [SUM_W-1:0]  b_sums_reg [LANES];
    // Product stage.
    logic                     c_valid_reg;
    logic signed [DELTA_W-1:0] c_delta_reg;
    logic signed [PROD_W-1:0] c_prod_reg [LANES];
    logic signed [PROD_W-1:0] c_prod_next [LANES];
    // Rounded and saturated features.
    logic                     d_valid_reg;
    logic signed [DELTA_W-1:0] d_delta_reg;
    logic signed [FEAT_W-1:0] d_feat_reg [LANES];
    logic signed [FEAT_W-1:0] d_feat_next [LANES];
    // Output register.
    logic                     e_valid_reg;
    logic [M_DATA_W-1:0]      e_data_reg;
    logic [M_DATA_W-1:0]      e_data_next;

    logic b_ready, c_ready, d_ready, e_ready;

    logic [PROD_W-1:0]        rnd_sum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SAT_W-1:0]  rnd_ext;
    logic [CSUM_W-1:0]        csum;
    logic signed [CRND_W-1:0] crnd;
    logic [COARSE_W-1:0]      coarse;

    // Each stage moves on when the one after it is empty or moving.
    assign e_ready  = !e_valid_reg || m_axis_tready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    // Scale each sum by the inverse root of the length.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            c_prod_next[i] = PROD_W'(b_sums_reg[i])
                           * PROD_W'($signed({1'b0, inverse_root_length}));
    end

    // Drop 16 fraction bits, rounding half away from zero, then saturate.
    always_comb
    begin
        rnd_sum = '0;
        rnd     = '0;
        rnd_ext = '0;
        for (int i = 0; i < LANES; i++)
        begin
            rnd_sum = c_prod_reg[i] + (c_prod_reg[i][PROD_W-1] ? FHALF - PROD_W'(1) : FHALF);
            rnd     = rnd_sum[PROD_W-1:FEAT_FRAC_SHIFT];
            rnd_ext = SAT_W'(rnd);
            if (rnd_ext > SAT_MAX)
                d_feat_next[i] = FEAT_W'(SAT_MAX);
            else if (rnd_ext < SAT_MIN)
                d_feat_next[i] = FEAT_W'(SAT_MIN);
            else
                d_feat_next[i] = FEAT_W'(rnd_ext);
        end
    end

    // Pack the result item; coarse fields are features in sixteenths.
    always_comb
    begin
        csum   = '0;
        crnd   = '0;
        coarse = '0;
        e_data_next = '0;
        e_data_next[DELTA_W-1:0] = d_delta_reg;
        for (int i = 0; i < LANES; i++)
            e_data_next[DELTA_W + i * FEAT_W +: FEAT_W] = d_feat_reg[i];
        for (int i = 0; i < CLANES; i++)
        begin
            csum = {d_feat_reg[i][FEAT_W-1], d_feat_reg[i]}
                 + (d_feat_reg[i][FEAT_W-1] ? CHALF - CSUM_W'(1) : CHALF);
            crnd = csum[CSUM_W-1:COARSE_SHIFT];
            if (crnd > CMAX)
                coarse = COARSE_W'(CMAX);
            else if (crnd < CMIN)
                coarse = COARSE_W'(CMIN);
            else
                coarse = COARSE_W'(crnd);
            e_data_next[COARSE_LSB + i * COARSE_W +: COARSE_W] = coarse;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= in_valid;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
            if (e_ready)
                e_valid_reg <= d_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_delta_reg <= in_delta;
            for (int i = 0; i < LANES; i++)
                b_sums_reg[i] <= in_sums[i];
        end
        if (c_ready)
        begin
            c_delta_reg <= b_delta_reg;
            for (int i = 0; i < LANES; i++)
                c_prod_reg[i] <= c_prod_next[i];
        end
        if (d_ready)
        begin
            d_delta_reg <= c_delta_reg;
            for (int i = 0; i < LANES; i++)
                d_feat_reg[i] <= d_feat_next[i];
        end
        if (e_ready)
            e_data_reg <= e_data_next;
    end

    assign m_axis_tvalid = e_valid_reg;
    assign m_axis_tdata  = e_data_reg;

    a_product_held: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && !d_ready |=> c_valid_reg)
        else $error("product stage dropped an item while blocked");

endmodule

// ===== tb/hsps_sketch_checker.sv =====
`timescale 1ns / 1ps

package hsps_sketch_tb_pkg;
    import hsps_pkg::*;

    // Sizes of the projection that the checker mirrors.
    localparam int LANES        = 4;
    localparam int COARSE_LANES = 2;
    localparam int SUM_W        = 38;
    localparam int LENGTH_CAP   = 8192;

    // Sign hash of one lane and coordinate.
    localparam logic [31:0] SIGN_MUL_LANE     = 32'd2654435761;
    localparam logic [31:0] SIGN_MUL_COORD    = 32'd2246822519;
    localparam logic [31:0] SIGN_LANE_OFFSET  = 32'd3;
    localparam logic [31:0] SIGN_COORD_OFFSET = 32'd29;
    localparam int          SIGN_FOLD         = 13;

    // One result item as it sits on the master tdata, target_delta lowest.
    typedef struct packed {
        logic [M_DATA_W-M_DATA_BITS-1:0] zero_fill;
        logic signed [COARSE_W-1:0]      coarse_one;
        logic signed [COARSE_W-1:0]      coarse_zero;
        logic signed [FEAT_W-1:0]        feature_three;
        logic signed [FEAT_W-1:0]        feature_two;
        logic signed [FEAT_W-1:0]        feature_one;
        logic signed [FEAT_W-1:0]        feature_zero;
        logic signed [DELTA_W-1:0]       target_delta;
    } sketch_t;

    // True when the difference is added into this lane at this coordinate.
    function automatic bit lane_sign_positive(input int unsigned lane, input int unsigned coord);
        logic [31:0] h;
        h = ((lane + SIGN_LANE_OFFSET) * SIGN_MUL_LANE)
            ^ ((coord + SIGN_COORD_OFFSET) * SIGN_MUL_COORD);
        h = h ^ (h >> SIGN_FOLD);
        return h[0];
    endfunction

endpackage

module hsps_sketch_checker
    import hsps_pkg::*;
    import hsps_sketch_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_DATA_W-1:0]   m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    output int                    mismatch_count,
    output int                    pending_results
);

    localparam int FEAT_SHIFT = 16;
    localparam int SIXTEENTH_SHIFT = 12;
    localparam longint FEAT_HI = 64'sd2147483647;
    localparam longint FEAT_LO = -64'sd2147483648;
    localparam longint COARSE_HI = 64'sd524287;
    localparam longint COARSE_LO = -64'sd524288;

    // Shadow copy of the registers and of the accumulator state.
    logic [VLEN_W-1:0]       length_reg;
    logic [IRL_W-1:0]        scale_reg;
    int unsigned             coord_index;
    logic signed [SUM_W-1:0] lane_sums [LANES];
    sketch_t                 expected_sketches [$];

    // Divide by 2^shift, rounding half away from zero.
    function automatic longint round_half_away(input longint value, input int shift);
        longint mag;
        mag = (value < 0) ? -value : value;
        mag = (mag + (longint'(1) << (shift - 1))) >>> shift;
        return (value < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp(input longint value, input longint lo, input longint hi);
        return (value < lo) ? lo : ((value > hi) ? hi : value);
    endfunction

    // Zero acts as one coordinate, anything past the cap as the cap.
    function automatic int unsigned vector_span();
        int unsigned n;
        n = length_reg;
        if (n == 0) n = 1;
        if (n > LENGTH_CAP) n = LENGTH_CAP;
        return n;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Fold one coordinate into the lane sums; close the vector on its last one.
    task automatic absorb_coordinate(input logic [S_DATA_W-1:0] data);
        logic signed [VALUE_W-1:0] clean_v;
        logic signed [VALUE_W-1:0] interv_v;
        logic signed [VALUE_W-1:0] clean_m;
        logic signed [VALUE_W-1:0] interv_m;
        logic signed [DELTA_W-1:0] diff;
        longint                    feats [LANES];
        sketch_t                   s;
        clean_v  = data[VALUE_W-1:0];
        interv_v = data[2*VALUE_W-1:VALUE_W];
        clean_m  = data[3*VALUE_W-1:2*VALUE_W];
        interv_m = data[4*VALUE_W-1:3*VALUE_W];
        diff = interv_v - clean_v;
        for (int f = 0; f < LANES; f++) begin
            if (lane_sign_positive(f, coord_index)) lane_sums[f] = lane_sums[f] + diff;
            else lane_sums[f] = lane_sums[f] - diff;
        end
        if (coord_index + 1 < vector_span()) begin
            coord_index++;
        end
        else begin
            s = '0;
            s.target_delta = interv_m - clean_m;
            for (int f = 0; f < LANES; f++) begin
                feats[f] = clamp(round_half_away(longint'(lane_sums[f]) * longint'(scale_reg),
                                                 FEAT_SHIFT), FEAT_LO, FEAT_HI);
            end
            s.feature_zero  = FEAT_W'(feats[0]);
            s.feature_one   = FEAT_W'(feats[1]);
            s.feature_two   = FEAT_W'(feats[2]);
            s.feature_three = FEAT_W'(feats[3]);
            s.coarse_zero = COARSE_W'(clamp(round_half_away(feats[0], SIXTEENTH_SHIFT),
                                            COARSE_LO, COARSE_HI));
            s.coarse_one  = COARSE_W'(clamp(round_half_away(feats[1], SIXTEENTH_SHIFT),
                                            COARSE_LO, COARSE_HI));
            expected_sketches.push_back(s);
            coord_index = 0;
            for (int f = 0; f < LANES; f++) lane_sums[f] = '0;
        end
    endtask

    // Compare one result item with the oldest expectation.
    task automatic compare_sketch(input sketch_t got);
        sketch_t want;
        if (expected_sketches.size() == 0) begin
            $error("result item with no expectation waiting: %h", got);
            mismatch_count++;
        end
        else begin
            want = expected_sketches.pop_front();
            check_field("target_delta", want.target_delta, got.target_delta);
            check_field("feature_zero", want.feature_zero, got.feature_zero);
            check_field("feature_one", want.feature_one, got.feature_one);
            check_field("feature_two", want.feature_two, got.feature_two);
            check_field("feature_three", want.feature_three, got.feature_three);
            check_field("coarse_zero", want.coarse_zero, got.coarse_zero);
            check_field("coarse_one", want.coarse_one, got.coarse_one);
            check_field("zero_fill", want.zero_fill, got.zero_fill);
        end
    endtask

    // Follow register traffic and both streams at every clock edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            length_reg  = VLEN_RESET;
            scale_reg   = IRL_RESET;
            coord_index = 0;
            for (int f = 0; f < LANES; f++) lane_sums[f] = '0;
            expected_sketches.delete();
            mismatch_count  = 0;
            pending_results = 0;
        end
        else begin
            if (psel && penable && pready && pwrite) begin
                case (paddr[APB_ADDR_W-1:REG_ADDR_LSB])
                    REG_VECTOR_LENGTH: length_reg = pwdata[VLEN_W-1:0];
                    REG_INVERSE_ROOT:  scale_reg  = pwdata[IRL_W-1:0];
                    default: ;
                endcase
            end
            if (psel && penable && pready && !pwrite) begin
                if (paddr[APB_ADDR_W-1:REG_ADDR_LSB] == REG_VECTOR_LENGTH)
                    check_field("prdata", APB_DATA_W'(length_reg), prdata);
                else
                    check_field("prdata", APB_DATA_W'(scale_reg), prdata);
            end
            if (s_axis_tvalid && s_axis_tready) absorb_coordinate(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) compare_sketch(sketch_t'(m_axis_tdata));
            pending_results = expected_sketches.size();
        end
    end

endmodule

// ===== tb/hashed_sign_projection_sketch_tb.sv =====
`timescale 1ns / 1ps

module hashed_sign_projection_sketch_tb;
    import hsps_pkg::*;
    import hsps_sketch_tb_pkg::*;

    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     RANDOM_ITEMS = 600;
    localparam int     ALIGNED_SPAN = 80;
    localparam int     RESET_SPAN   = 200;
    localparam int     CAP_SPAN     = 150;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;
    localparam logic [31:0] SCALE_ONE = 32'd65536;
    localparam logic [31:0] SCALE_MAX = 32'd131071;
    localparam logic [31:0] LENGTH_OVER_CAP = 32'd16383;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int     mismatch_count;
    int     pending_results;
    int     source_idle_max = 0;
    int     sink_idle_max = 0;
    int     random_sent;
    longint cycle_count = 0;

    hashed_sign_projection_sketch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hsps_sketch_checker sketch_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: a random number of stall cycles before each item.
    initial
    begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            gap = (sink_idle_max == 0) ? 0 : $urandom_range(0, sink_idle_max);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic logic signed [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2, 3: return VALUE_W'(int'($urandom_range(0, 131071)) - 65536);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly short vectors so that results come often.
    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'($urandom_range(9, 40));
            2: return ($urandom << VLEN_W) | 32'($urandom_range(1, 6));
            default: return 32'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return SCALE_ONE;
            3: return SCALE_MAX;
            4: return ($urandom << IRL_W) | 32'($urandom_range(0, 131071));
            5, 6: return 32'($urandom_range(0, 131071));
            default: return 32'($urandom_range(8192, 70000));
        endcase
    endfunction

    function automatic int pick_idle_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 10;
        endcase
    endfunction

    // Offer one coordinate item after a random gap and hold it until taken.
    task automatic send_coord(input logic signed [VALUE_W-1:0] clean_v,
                              input logic signed [VALUE_W-1:0] interv_v,
                              input logic signed [VALUE_W-1:0] clean_m,
                              input logic signed [VALUE_W-1:0] interv_m);
        int gap;
        gap = (source_idle_max == 0) ? 0 : $urandom_range(0, source_idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {interv_m, clean_m, interv_v, clean_v};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_coord(draw_value(), draw_value(), draw_value(), draw_value());
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register access: setup cycle, then access cycle.
    task automatic reg_access(input logic is_write, input reg_index_t index,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(index) << REG_ADDR_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] length, input logic [31:0] scale);
        reg_access(1'b1, REG_VECTOR_LENGTH, length);
        reg_access(1'b1, REG_INVERSE_ROOT, scale);
        reg_access(1'b0, REG_VECTOR_LENGTH, '0);
        reg_access(1'b0, REG_INVERSE_ROOT, '0);
    endtask

    // Vector whose differences all push one lane the same way, to drive saturation.
    task automatic send_aligned(input int lane, input bit upward);
        for (int c = 0; c < ALIGNED_SPAN; c++)
        begin
            if (lane_sign_positive(lane, c) == upward)
                send_coord(VALUE_MIN, VALUE_MAX, draw_value(), draw_value());
            else
                send_coord(VALUE_MAX, VALUE_MIN, draw_value(), draw_value());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: part of a vector at the default length and scale,
        // then a length of one closes it with the default scale.
        reg_access(1'b0, REG_VECTOR_LENGTH, '0);
        reg_access(1'b0, REG_INVERSE_ROOT, '0);
        source_idle_max = 2;
        sink_idle_max   = 3;
        send_random(RESET_SPAN);
        drain_results();
        reg_access(1'b1, REG_VECTOR_LENGTH, 32'd1);
        send_random(1);
        drain_results();

        // Unit scale, one coordinate per vector: field extremes and rounding ties.
        source_idle_max = 10;
        sink_idle_max   = 10;
        set_config(32'd1, SCALE_ONE);
        send_coord(VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX);
        send_coord(VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MIN);
        send_coord(24'sd0, 24'sd2048, 24'sd0, 24'sd0);
        send_coord(24'sd2048, 24'sd0, 24'sd0, 24'sd0);
        send_coord(24'sd0, 24'sd6144, 24'sd5, -24'sd5);
        send_coord(-24'sd1, -24'sd1, -24'sd1, -24'sd1);
        drain_results();

        // Smallest scale: a product of exactly one half rounds away from zero.
        set_config(32'd1, 32'd1);
        send_coord(24'sd0, 24'sd32768, 24'sd0, 24'sd1);
        send_coord(24'sd0, 24'sd32767, 24'sd1, 24'sd0);
        send_coord(24'sd32768, 24'sd0, VALUE_MAX, VALUE_MAX);
        drain_results();

        // Zero scale gives zero features.
        set_config(32'd1, 32'd0);
        send_coord(VALUE_MIN, VALUE_MAX, draw_value(), draw_value());
        send_coord(draw_value(), draw_value(), draw_value(), draw_value());
        drain_results();

        // Length zero acts as a single coordinate.
        set_config(32'd0, SCALE_MAX);
        send_random(2);
        drain_results();

        // Length lowered below the coordinates already taken: next item closes.
        set_config(32'd8192, pick_scale());
        send_random(6);
        drain_results();
        set_config(32'd3, pick_scale());
        send_coord(draw_value(), draw_value(), draw_value(), draw_value());
        send_random(3);
        drain_results();

        // Saturation of features and sixteenths at full scale.
        set_config(32'd1, SCALE_MAX);
        send_random(1);
        drain_results();
        set_config(32'(ALIGNED_SPAN), SCALE_MAX);
        send_aligned(0, 1'b1);
        send_aligned(1, 1'b0);
        send_aligned(2, 1'b0);
        drain_results();

        // Length above the cap keeps the vector open; a short length then closes it.
        source_idle_max = 1;
        sink_idle_max   = 0;
        set_config(LENGTH_OVER_CAP, pick_scale());
        send_random(CAP_SPAN);
        drain_results();
        reg_access(1'b1, REG_VECTOR_LENGTH, 32'd2);
        send_random(1);
        drain_results();

        // Random phases with random settings, some changed mid-vector.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            int count;
            drain_results();
            source_idle_max = pick_idle_max();
            sink_idle_max   = pick_idle_max();
            if ($urandom_range(0, 3) != 0) reg_access(1'b1, REG_VECTOR_LENGTH, pick_length());
            if ($urandom_range(0, 3) != 0) reg_access(1'b1, REG_INVERSE_ROOT, pick_scale());
            if ($urandom_range(0, 4) == 0)
            begin
                reg_access(1'b0, REG_VECTOR_LENGTH, '0);
                reg_access(1'b0, REG_INVERSE_ROOT, '0);
            end
            count = $urandom_range(10, 60);
            send_random(count);
            random_sent += count;
        end
        drain_results();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hsps_pkg.sv
sv/hsps_cfg.sv
sv/hsps_accum.sv
sv/hsps_finish.sv
sv/hashed_sign_projection_sketch.sv
tb/hsps_sketch_checker.sv
tb/hashed_sign_projection_sketch_tb.sv
